// ----- hw/rtl/tsso_pkg.sv -----
// ----------------------------------------------------------------------------
// tsso_pkg: shared types and codes for the two-set table
// Item layouts, command and status codes, and the result request that the
// sequencer hands to the result stage.
// ----------------------------------------------------------------------------
package tsso_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int SIZE_W   = 6;

  // commands
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_UNION  = 3'd4;
  localparam logic [2:0] CMD_INTER  = 3'd5;
  localparam logic [2:0] CMD_DIFF   = 3'd6;

  // result status
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [2:0]               cmd;
    logic                     which_set;
    logic signed [DATA_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic [2:0]               status;
    logic [SIZE_W-1:0]        size_now;
  } out_item_t;

  // single: complete one-item result; push: one streamed element;
  // fin: end of stream (flush held element, or emit empty result)
  typedef struct packed {
    logic      single;
    logic      push;
    logic      fin;
    out_item_t item;
  } emit_req_t;

endpackage

// ----- hw/rtl/two_set_table_with_set_ops.sv -----
// ----------------------------------------------------------------------------
// two_set_table_with_set_ops: two sets of 32-bit values with set operations
// Clear completes without a scan; insert, delete and find scan the target set,
//   stopping early on a hit; a delete of a present item then shifts entries down.
// Set ops walk one set and scan the other for each outer element; a union copies
//   each A element as is, and the last item is flushed; one RAM read per cycle.
// One item at a time: start is taken whenever busy is low; results cannot stall.
// Reset clears both set sizes; entry RAMs are left as they are.
// ----------------------------------------------------------------------------
module two_set_table_with_set_ops #(
  parameter int CAPACITY = tsso_pkg::CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tsso_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tsso_pkg::out_item_t out_item
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW    = tsso_pkg::DATA_W;

  // shared write/read addresses: only one set is written in any cycle
  logic                a_we, b_we;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [DW-1:0]       wdata;
  logic [DW-1:0]       a_rdata, b_rdata;
  tsso_pkg::emit_req_t req;

  // set A entries, compacted in insertion order
  tsso_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  // set B entries
  tsso_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  // command sequencer: scans, delete shifts, set-op walk
  tsso_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .a_we    (a_we),
    .b_we    (b_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .req     (req)
  );

  // result stage: one-item hold-back to place the last mark
  tsso_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- hw/rtl/tsso_ram.sv -----
// ----------------------------------------------------------------------------
// tsso_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tsso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/tsso_emit.sv -----
// ----------------------------------------------------------------------------
// tsso_emit: result stage
// Holds one streamed element back so the last mark is known when it leaves;
// drives the registered result strobe and item.
// ----------------------------------------------------------------------------
module tsso_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsso_pkg::emit_req_t  req,
  output logic                 out_valid,
  output tsso_pkg::out_item_t  out_item
);

  logic                pend_vld_r, pend_vld_nxt;
  tsso_pkg::out_item_t pend_r, pend_nxt;
  logic                out_vld_r, out_vld_nxt;
  tsso_pkg::out_item_t out_r, out_nxt;

  always_comb begin
    out_vld_nxt  = 1'b0;
    out_nxt      = out_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    if (req.single) begin
      out_vld_nxt  = 1'b1;
      out_nxt      = req.item;
      out_nxt.last = 1'b1;
    end else if (req.push) begin
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = pend_r;
        out_nxt.last = 1'b0;
      end
      pend_nxt     = req.item;
      pend_vld_nxt = 1'b1;
    end else if (req.fin) begin
      out_vld_nxt = 1'b1;
      if (pend_vld_r) begin
        out_nxt      = pend_r;
        out_nxt.last = 1'b1;
        pend_vld_nxt = 1'b0;
      end else begin
        out_nxt.hit      = 1'b0;
        out_nxt.value    = '0;
        out_nxt.last     = 1'b1;
        out_nxt.status   = tsso_pkg::ST_EMPTY;
        out_nxt.size_now = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

// ----- hw/rtl/tsso_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsso_ctrl: command sequencer
// Keeps set sizes, runs pipelined membership scans and delete shifts over
// the two entry RAMs, and walks the outer loop of the set operations.
// ----------------------------------------------------------------------------
module tsso_ctrl #(
  parameter int CAPACITY = tsso_pkg::CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1),
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int DW      = tsso_pkg::DATA_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tsso_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                a_we,
  output logic                b_we,
  output logic [IDX_W-1:0]    waddr,
  output logic [DW-1:0]       wdata,
  output logic [IDX_W-1:0]    raddr,
  input  logic [DW-1:0]       a_rdata,
  input  logic [DW-1:0]       b_rdata,
  output tsso_pkg::emit_req_t req
);

  localparam int SW = tsso_pkg::SIZE_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_OUTER = 5'b01000,
    S_OLOAD = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [DW-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0] size_a_r, size_a_nxt;
  logic [CNT_W-1:0] size_b_r, size_b_nxt;
  logic [CNT_W-1:0] q_r, q_nxt;
  logic             chk_r, chk_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             phase_r, phase_nxt;
  logic             scan_b_r, scan_b_nxt;

  logic [CNT_W-1:0] limit;
  logic [DW-1:0]    rdata;
  logic             issue;
  logic             match;
  logic             is_setop;
  logic             take;

  function automatic tsso_pkg::out_item_t mk_item(input logic hit, input logic [DW-1:0] val,
                                                  input logic [2:0] st,
                                                  input logic [SW-1:0] sz);
    tsso_pkg::out_item_t it;
    it.hit      = hit;
    it.value    = val;
    it.last     = 1'b0;
    it.status   = st;
    it.size_now = sz;
    return it;
  endfunction

  assign limit    = scan_b_r ? size_b_r : size_a_r;
  assign rdata    = scan_b_r ? b_rdata : a_rdata;
  assign issue    = (q_r < limit);
  assign match    = chk_r && (rdata == key_r);
  assign is_setop = (cmd_r == tsso_pkg::CMD_UNION) || (cmd_r == tsso_pkg::CMD_INTER) ||
                    (cmd_r == tsso_pkg::CMD_DIFF);
  assign take     = (cmd_r == tsso_pkg::CMD_INTER) ? match : !match;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    size_a_nxt  = size_a_r;
    size_b_nxt  = size_b_r;
    q_nxt       = q_r;
    chk_nxt     = chk_r;
    chk_idx_nxt = chk_idx_r;
    i_nxt       = i_r;
    n_nxt       = n_r;
    phase_nxt   = phase_r;
    scan_b_nxt  = scan_b_r;
    a_we        = 1'b0;
    b_we        = 1'b0;
    waddr       = limit[IDX_W-1:0];
    wdata       = key_r;
    raddr       = q_r[IDX_W-1:0];
    req         = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_item.cmd;
          key_nxt    = in_item.element;
          scan_b_nxt = in_item.which_set;
          q_nxt      = '0;
          chk_nxt    = 1'b0;
          i_nxt      = '0;
          n_nxt      = '0;
          phase_nxt  = 1'b0;
          case (in_item.cmd)
            tsso_pkg::CMD_CLEAR: begin
              if (in_item.which_set) begin
                size_b_nxt = '0;
              end else begin
                size_a_nxt = '0;
              end
              req.single = 1'b1;
              req.item   = mk_item(1'b0, '0, tsso_pkg::ST_OK, '0);
            end
            tsso_pkg::CMD_INSERT, tsso_pkg::CMD_DELETE, tsso_pkg::CMD_FIND: begin
              state_nxt = S_SCAN;
            end
            tsso_pkg::CMD_UNION, tsso_pkg::CMD_INTER, tsso_pkg::CMD_DIFF: begin
              state_nxt = S_OUTER;
            end
            default: begin
              // unused code: no result
            end
          endcase
        end
      end

      S_SCAN: begin
        // read entry q while comparing the entry from the previous read
        chk_nxt     = issue && !match;
        chk_idx_nxt = q_r[IDX_W-1:0];
        if (issue) begin
          q_nxt = q_r + 1'b1;
        end
        if (match || (!issue && !chk_r)) begin
          if (is_setop) begin
            if (take && (n_r < CAP)) begin
              req.push = 1'b1;
              req.item = mk_item(1'b0, key_r, tsso_pkg::ST_OK, SW'(n_r + 1'b1));
              n_nxt    = n_r + 1'b1;
            end
            i_nxt     = i_r + 1'b1;
            state_nxt = S_OUTER;
          end else begin
            state_nxt = S_IDLE;
            case (cmd_r)
              tsso_pkg::CMD_INSERT: begin
                req.single = 1'b1;
                if (match) begin
                  req.item = mk_item(1'b0, '0, tsso_pkg::ST_DUP, SW'(limit));
                end else if (limit >= CAP) begin
                  req.item = mk_item(1'b0, '0, tsso_pkg::ST_FULL, SW'(limit));
                end else begin
                  a_we     = !scan_b_r;
                  b_we     = scan_b_r;
                  if (scan_b_r) begin
                    size_b_nxt = size_b_r + 1'b1;
                  end else begin
                    size_a_nxt = size_a_r + 1'b1;
                  end
                  req.item = mk_item(1'b0, '0, tsso_pkg::ST_OK, SW'(limit + 1'b1));
                end
              end
              tsso_pkg::CMD_DELETE: begin
                if (match) begin
                  // close the gap: move entries above the hit down by one
                  q_nxt     = CNT_W'(chk_idx_r) + 1'b1;
                  chk_nxt   = 1'b0;
                  state_nxt = S_SHIFT;
                end else begin
                  req.single = 1'b1;
                  req.item   = mk_item(1'b0, '0, tsso_pkg::ST_ABSENT, SW'(limit));
                end
              end
              default: begin
                req.single = 1'b1;
                req.item   = mk_item(match, '0, match ? tsso_pkg::ST_OK : tsso_pkg::ST_ABSENT,
                                     SW'(limit));
              end
            endcase
          end
        end
      end

      S_SHIFT: begin
        // read q, write it back to q-1 next cycle; writes trail reads
        if (chk_r) begin
          a_we  = !scan_b_r;
          b_we  = scan_b_r;
          waddr = chk_idx_r - 1'b1;
          wdata = rdata;
        end
        chk_nxt     = issue;
        chk_idx_nxt = q_r[IDX_W-1:0];
        if (issue) begin
          q_nxt = q_r + 1'b1;
        end
        if (!issue && !chk_r) begin
          if (scan_b_r) begin
            size_b_nxt = size_b_r - 1'b1;
          end else begin
            size_a_nxt = size_a_r - 1'b1;
          end
          req.single = 1'b1;
          req.item   = mk_item(1'b1, '0, tsso_pkg::ST_OK, SW'(limit - 1'b1));
          state_nxt  = S_IDLE;
        end
      end

      S_OUTER: begin
        raddr = i_r[IDX_W-1:0];
        if (!phase_r) begin
          if (i_r < size_a_r) begin
            scan_b_nxt = 1'b0;
            state_nxt  = S_OLOAD;
          end else if (cmd_r == tsso_pkg::CMD_UNION) begin
            phase_nxt = 1'b1;
            i_nxt     = '0;
          end else begin
            req.fin   = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          if ((i_r < size_b_r) && (n_r < CAP)) begin
            scan_b_nxt = 1'b1;
            state_nxt  = S_OLOAD;
          end else begin
            req.fin   = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_OLOAD: begin
        key_nxt = rdata;
        if ((cmd_r == tsso_pkg::CMD_UNION) && !phase_r) begin
          // every element of A goes into the union
          req.push  = 1'b1;
          req.item  = mk_item(1'b0, rdata, tsso_pkg::ST_OK, SW'(n_r + 1'b1));
          n_nxt     = n_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_OUTER;
        end else begin
          // look the element up in the other set
          scan_b_nxt = !scan_b_r;
          q_nxt      = '0;
          chk_nxt    = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      size_a_r <= '0;
      size_b_r <= '0;
      chk_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      size_a_r <= size_a_nxt;
      size_b_r <= size_b_nxt;
      chk_r    <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    q_r       <= q_nxt;
    chk_idx_r <= chk_idx_nxt;
    i_r       <= i_nxt;
    n_r       <= n_nxt;
    phase_r   <= phase_nxt;
    scan_b_r  <= scan_b_nxt;
  end

endmodule
